/* rtl/sqjs_pkg.sv */
// shared constants, types and widths for the squared jensen-shannon accumulator
// no dependencies; imported by every module of the block
package sqjs_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int SUM_BITS    = 48;

  localparam int FRAC_BITS = 24;
  localparam int MANT_W    = 31;
  localparam int XW        = SAMPLE_BITS + 1;
  localparam int EW        = $clog2(XW);
  localparam int LOG_W     = EW + FRAC_BITS;
  localparam int LNP_W     = LOG_W + 30;
  localparam int TP_W      = SAMPLE_BITS + LOG_W;
  localparam int TERM_W    = LOG_W + 2;
  localparam int SCALE_W   = 24;
  localparam int OUT_W     = 32;
  localparam int LO_W      = 24;
  localparam int HI_W      = SUM_BITS - 1 - LO_W;
  localparam int PROD_W    = SUM_BITS - 1 + SCALE_W;
  localparam int CNT_W     = $clog2(FRAC_BITS);

  localparam logic [29:0]        LN2_Q30     = 30'd744261118;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(32768);
  localparam logic [63:0]        OUT_LIMIT   = (64'd1 << 48) - (64'd1 << 15);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] p;
    logic [SAMPLE_BITS-1:0] q;
    logic [SAMPLE_BITS:0]   s;
    logic                   p_zero;
    logic                   q_zero;
    logic                   last;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t work;
  } head_t;

endpackage

/* rtl/sqjs_front.sv */
// front end: input handshake, element classification and a two-entry work queue
// depends on sqjs_pkg
module sqjs_front import sqjs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] p_value,
  input  logic [SAMPLE_BITS-1:0] q_value,
  input  logic                   last_element,
  input  logic                   pop,
  output head_t                  head
);

  work_t      entry [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  work_t      incoming;

  always_comb begin
    incoming.p      = p_value;
    incoming.q      = q_value;
    incoming.s      = {1'b0, p_value} + {1'b0, q_value};
    incoming.p_zero = (p_value == '0);
    incoming.q_zero = (q_value == '0);
    incoming.last   = last_element;
  end

  assign in_stall   = (count == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head.valid = (count != 2'd0);
  assign head.work  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/sqjs_log2.sv */
// iterative log2 unit: normalizes on load, then one squaring per step
// depends on sqjs_pkg
module sqjs_log2 import sqjs_pkg::*; (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [XW-1:0]    x,
  output logic [LOG_W-1:0] result
);

  logic [EW-1:0]        expo;
  logic [MANT_W-1:0]    mant;
  logic [FRAC_BITS-1:0] frac;
  logic [EW-1:0]        msb;
  logic [XW-1:0]        xn;
  logic [63:0]          wide;
  logic [2*MANT_W-1:0]  sq;
  logic [MANT_W:0]      ms;

  always_comb begin
    msb = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) begin
        msb = EW'(i);
      end
    end
    xn   = x << (EW'(XW - 1) - msb);
    wide = {xn, {(64 - XW){1'b0}}};
    sq   = mant * mant;
    ms   = sq[2*MANT_W-1:30];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      expo <= msb;
      mant <= wide[63 -: MANT_W];
      frac <= '0;
    end else if (step) begin
      if (ms[MANT_W]) begin
        mant <= ms[MANT_W:1];
      end else begin
        mant <= ms[MANT_W-1:0];
      end
      frac <= {frac[FRAC_BITS-2:0], ms[MANT_W]};
    end
  end

  assign result = {expo, frac};

endmodule

/* rtl/sqjs_back.sv */
// back end: log sequencing, term arithmetic, running sum, final scaling, result register
// depends on sqjs_pkg and sqjs_log2
module sqjs_back import sqjs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  head_t              head,
  output logic               pop,
  input  logic               cfg_wr_en,
  input  logic [SCALE_W-1:0] cfg_wr_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [OUT_W-1:0]   divergence,
  output logic               saturated
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ITER = 4'd1;
  localparam logic [3:0] S_DIFF = 4'd2;
  localparam logic [3:0] S_LNM  = 4'd3;
  localparam logic [3:0] S_RND  = 4'd4;
  localparam logic [3:0] S_TMUL = 4'd5;
  localparam logic [3:0] S_TRND = 4'd6;
  localparam logic [3:0] S_ADDP = 4'd7;
  localparam logic [3:0] S_ADDQ = 4'd8;
  localparam logic [3:0] S_FMUL = 4'd9;
  localparam logic [3:0] S_FADD = 4'd10;
  localparam logic [3:0] S_FOUT = 4'd11;

  logic [3:0]               state;
  logic [CNT_W-1:0]         cnt;
  work_t                    cur;
  logic [SCALE_W-1:0]       scale;
  logic signed [SUM_BITS-1:0] running_sum;

  logic [LOG_W-1:0]  log_p, log_q, log_s;
  logic              log_load, log_step;
  logic [XW-1:0]     two_p, two_q;

  logic              neg_p, neg_q;
  logic [LOG_W-1:0]  dmag_p, dmag_q;
  logic [LNP_W-1:0]  lprod_p, lprod_q;
  logic [LOG_W-1:0]  lnmag_p, lnmag_q;
  logic [TP_W-1:0]   tprod_p, tprod_q;
  logic signed [TERM_W-1:0] term_p, term_q;

  logic [2*LO_W-1:0]     part_lo;
  logic [HI_W+SCALE_W-1:0] part_hi;
  logic [PROD_W-1:0]     prod;
  logic                  cls_neg, cls_zero;
  logic                  load_out;

  logic signed [LOG_W:0] diff_p, diff_q;
  logic [LNP_W-1:0]      lround_p, lround_q;
  logic [TP_W-1:0]       tround_p, tround_q;
  logic [TERM_W-1:0]     tmag_p, tmag_q;
  logic signed [SUM_BITS-1:0] add_sel;
  logic signed [TERM_W-1:0]   term_sel;
  logic signed [SUM_BITS:0]   add_wide;
  logic signed [SUM_BITS-1:0] sat_sum;
  logic [PROD_W-1:0]     out_round;
  logic                  over;

  assign two_p    = {head.work.p, 1'b0};
  assign two_q    = {head.work.q, 1'b0};
  assign pop      = (state == S_IDLE) && head.valid;
  assign log_load = pop;
  assign log_step = (state == S_ITER);

  sqjs_log2 u_log_p (.clk, .load(log_load), .step(log_step), .x(two_p),       .result(log_p));
  sqjs_log2 u_log_q (.clk, .load(log_load), .step(log_step), .x(two_q),       .result(log_q));
  sqjs_log2 u_log_s (.clk, .load(log_load), .step(log_step), .x(head.work.s), .result(log_s));

  always_comb begin
    diff_p   = $signed({1'b0, log_p}) - $signed({1'b0, log_s});
    diff_q   = $signed({1'b0, log_q}) - $signed({1'b0, log_s});
    lround_p = lprod_p + (LNP_W'(1) << 29);
    lround_q = lprod_q + (LNP_W'(1) << 29);
    tround_p = tprod_p + (TP_W'(1) << (SAMPLE_BITS - 2));
    tround_q = tprod_q + (TP_W'(1) << (SAMPLE_BITS - 2));
    tmag_p   = TERM_W'(tround_p >> (SAMPLE_BITS - 1));
    tmag_q   = TERM_W'(tround_q >> (SAMPLE_BITS - 1));
    term_sel = (state == S_ADDP) ? term_p : term_q;
    add_sel  = SUM_BITS'(term_sel);
    add_wide = {running_sum[SUM_BITS-1], running_sum} + {add_sel[SUM_BITS-1], add_sel};
    if (add_wide[SUM_BITS] != add_wide[SUM_BITS-1]) begin
      sat_sum = add_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                   : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      sat_sum = add_wide[SUM_BITS-1:0];
    end
    over      = (PROD_W'(OUT_LIMIT) <= prod);
    out_round = (prod + (PROD_W'(1) << 15)) >> 16;
    load_out  = (state == S_FOUT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.work;
    end
    unique case (state)
      S_DIFF: begin
        neg_p  <= diff_p[LOG_W];
        neg_q  <= diff_q[LOG_W];
        dmag_p <= diff_p[LOG_W] ? LOG_W'(-diff_p) : LOG_W'(diff_p);
        dmag_q <= diff_q[LOG_W] ? LOG_W'(-diff_q) : LOG_W'(diff_q);
      end
      S_LNM: begin
        lprod_p <= LNP_W'(dmag_p * LN2_Q30);
        lprod_q <= LNP_W'(dmag_q * LN2_Q30);
      end
      S_RND: begin
        lnmag_p <= LOG_W'(lround_p >> 30);
        lnmag_q <= LOG_W'(lround_q >> 30);
      end
      S_TMUL: begin
        tprod_p <= TP_W'(cur.p * lnmag_p);
        tprod_q <= TP_W'(cur.q * lnmag_q);
      end
      S_TRND: begin
        term_p <= cur.p_zero ? '0 : (neg_p ? -$signed(tmag_p) : $signed(tmag_p));
        term_q <= cur.q_zero ? '0 : (neg_q ? -$signed(tmag_q) : $signed(tmag_q));
      end
      S_FMUL: begin
        part_lo  <= running_sum[LO_W-1:0] * scale;
        part_hi  <= running_sum[SUM_BITS-2:LO_W] * scale;
        cls_neg  <= running_sum[SUM_BITS-1];
        cls_zero <= (running_sum == '0) || (scale == '0);
      end
      S_FADD: begin
        prod <= (PROD_W'(part_hi) << LO_W) + PROD_W'(part_lo);
      end
      default: begin
      end
    endcase
    if (load_out) begin
      priority if (cls_neg) begin
        divergence <= '0;
        saturated  <= 1'b1;
      end else if (cls_zero) begin
        divergence <= '0;
        saturated  <= 1'b0;
      end else if (over) begin
        divergence <= '1;
        saturated  <= 1'b1;
      end else begin
        divergence <= out_round[OUT_W-1:0];
        saturated  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            state <= S_ITER;
            cnt   <= '0;
          end
        end
        S_ITER: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(FRAC_BITS - 1)) begin
            state <= S_DIFF;
          end
        end
        S_DIFF: state <= S_LNM;
        S_LNM:  state <= S_RND;
        S_RND:  state <= S_TMUL;
        S_TMUL: state <= S_TRND;
        S_TRND: state <= S_ADDP;
        S_ADDP: begin
          running_sum <= sat_sum;
          state       <= S_ADDQ;
        end
        S_ADDQ: begin
          running_sum <= sat_sum;
          state       <= cur.last ? S_FMUL : S_IDLE;
        end
        S_FMUL: state <= S_FADD;
        S_FADD: state <= S_FOUT;
        S_FOUT: begin
          if (load_out) begin
            running_sum <= '0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == S_IDLE))
    else $error("queue popped while an item is in flight");

  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (running_sum == '0))
    else $error("running sum not cleared after a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> !$past(load_out))
    else $error("pending result overwritten");

endmodule

/* rtl/sq_jensen_shannon_accumulator.sv */
// top level of the squared jensen-shannon accumulator
// depends on sqjs_pkg, sqjs_front, sqjs_back (which holds sqjs_log2)
//
//   channel   handshake               payload
//   input     in_valid / in_stall     p_value, q_value, last_element
//   output    out_valid / out_stall   divergence, saturated
//   config    cfg_wr_en               cfg_wr_data (inverse_log_scale, Q8.16)
//
// each transaction runs in the back end through the squaring steps of the
// three log2 units (one 31x31 product each per step, one fraction bit each),
// then the term arithmetic; a last element adds the split 47x24 scaling multiply
// a two-entry queue keeps accepting input while the back end works, until it is full
// synchronous active-high reset clears the queue, the sum and the scale to 0.5
// out_stall only holds the result register; the back end waits on it only
// when a new result is ready and the previous one is still pending
module sq_jensen_shannon_accumulator import sqjs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] p_value,
  input  logic [SAMPLE_BITS-1:0] q_value,
  input  logic                   last_element,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OUT_W-1:0]       divergence,
  output logic                   saturated,
  input  logic                   cfg_wr_en,
  input  logic [SCALE_W-1:0]     cfg_wr_data
);

  // queue head and pop between front and back
  head_t head;
  logic  pop;

  // front: accept, classify zero elements, form p+q, buffer
  sqjs_front u_front (
    .clk, .rst, .in_valid, .in_stall, .p_value, .q_value, .last_element,
    .pop, .head
  );

  // back: logs, terms, running sum, final scaling and result register
  sqjs_back u_back (
    .clk, .rst, .head, .pop, .cfg_wr_en, .cfg_wr_data,
    .out_valid, .out_stall, .divergence, .saturated
  );

endmodule
